/* rtl/tt_pkg.sv */
package tt_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam logic [15:0] RATE_RESET = 16'd100;
	localparam logic [15:0] MS_PER_S = 16'd1000;
	localparam logic [31:0] MS_ROUND = 32'd999;
	// ceil(2^41 / 1000): exact division by 1000 for any 32-bit dividend
	localparam logic [31:0] MS_RECIP = 32'd2199023256;
	localparam int MS_RECIP_SHIFT = 41;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_REG = 2'd1;
	localparam logic [1:0] FUNC_SLEEP = 2'd2;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_WOKEN = 3'd1;
	localparam logic [2:0] EV_FIRED = 3'd2;
	localparam logic [2:0] EV_REGISTERED = 3'd3;
	localparam logic [2:0] EV_FULL = 3'd4;

	typedef struct packed {
		logic [1:0] func;
		logic [23:0] period_q8;
		logic [15:0] sleep_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [2:0] channel;
		logic [31:0] deadline;
		logic already_due;
		logic [31:0] tick_now;
		logic [31:0] uptime_seconds;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic valid;
		in_item_t item;
	} queue_head_t;

	typedef struct packed {
		logic start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_SMUL,
		S_SDIV,
		S_USTART,
		S_UDIV,
		S_WAKE,
		S_CRD,
		S_CCHK,
		S_CFIRE,
		S_CNEXT,
		S_RSCAN,
		S_RWR,
		S_SLEEP,
		S_EMIT,
		S_FIN
	} back_state_t;

endpackage

/* rtl/tt_front.sv */
module tt_front import tt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output queue_head_t head,
	input logic pop
);

	// two-entry item queue between the input channel and the sequencer
	in_item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic do_pop;

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign do_pop = pop && (count_q != 2'd0);
	assign head.valid = (count_q != 2'd0);
	assign head.item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/tt_div.sv */
module tt_div import tt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	// restoring divider, one quotient bit a cycle
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] div_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [16:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits = (trial >= {1'b0, div_q});
	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= 16'd0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/tt_back.sv */
module tt_back import tt_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_data,
	input queue_head_t head,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

	back_state_t state_q, state_d;
	back_state_t ret_q;

	logic [15:0] rate_q;
	logic [31:0] tc_q;
	logic [31:0] earliest_q;
	logic [31:0] upt_q;
	logic [31:0] end_q;
	logic [31:0] msr_q;
	logic [63:0] recip_q;
	logic [39:0] prod_q;
	logic [IW-1:0] idx_q;
	logic [CHANNELS-1:0] valid_q;
	in_item_t item_q;
	out_item_t res_q;
	out_item_t pend_q;
	logic pend_valid_q;
	out_item_t out_q;
	logic out_valid_q;

	logic [31:0] dl_mem [CHANNELS];
	logic [23:0] per_mem [CHANNELS];
	logic [31:0] dl_rd_q;
	logic [23:0] per_rd_q;

	div_req_t dreq;
	div_rsp_t drsp;
	logic out_free;
	logic out_load;
	out_item_t out_next;
	logic [31:0] new_dl;
	logic hit;

	tt_div u_div (
		.clk (clk),
		.arst_n (arst_n),
		.req (dreq),
		.rsp (drsp)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign new_dl = tc_q + prod_q[39:8];
	assign hit = valid_q[idx_q] && (tc_q >= dl_rd_q);

	always_ff @(posedge clk) begin
		if ((state_q == S_CFIRE) || (state_q == S_RWR)) begin
			dl_mem[idx_q] <= new_dl;
		end
		if (state_q == S_RWR) begin
			per_mem[idx_q] <= item_q.period_q8;
		end
		dl_rd_q <= dl_mem[idx_q];
		per_rd_q <= per_mem[idx_q];
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		dreq.start = 1'b0;
		dreq.dividend = tc_q;
		dreq.divisor = rate_q;
		out_load = 1'b0;
		out_next = pend_q;
		case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (item_q.func == FUNC_SLEEP) begin
					state_d = S_SMUL;
				end else begin
					state_d = S_USTART;
				end
			end
			S_SMUL: state_d = S_SDIV;
			S_SDIV: state_d = S_USTART;
			S_USTART: begin
				dreq.start = 1'b1;
				state_d = S_UDIV;
			end
			S_UDIV: begin
				if (drsp.done) begin
					case (item_q.func)
						FUNC_TICK: state_d = S_WAKE;
						FUNC_REG: state_d = S_RSCAN;
						FUNC_SLEEP: state_d = S_SLEEP;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_WAKE: state_d = (tc_q >= earliest_q) ? S_EMIT : S_CRD;
			S_CRD: state_d = S_CCHK;
			S_CCHK: state_d = hit ? S_CFIRE : S_CNEXT;
			S_CFIRE: state_d = S_EMIT;
			S_CNEXT: state_d = (idx_q == LAST_IDX) ? S_FIN : S_CRD;
			S_RSCAN: begin
				if (!valid_q[idx_q]) begin
					state_d = S_RWR;
				end else if (idx_q == LAST_IDX) begin
					state_d = S_EMIT;
				end
			end
			S_RWR: state_d = S_EMIT;
			S_SLEEP: state_d = S_EMIT;
			S_EMIT: begin
				if (!pend_valid_q) begin
					state_d = ret_q;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d = ret_q;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					if (!pend_valid_q) begin
						out_next = res_q;
						out_next.event_res = EV_NONE;
						out_next.channel = 3'd0;
						out_next.deadline = 32'd0;
						out_next.already_due = 1'b0;
						out_next.tick_now = tc_q;
						out_next.uptime_seconds = upt_q;
					end
					out_next.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
		if ((state_q == S_EMIT) && (!pend_valid_q || out_free)) begin
			pend_q <= res_q;
		end
		if (pop) begin
			item_q <= head.item;
		end
		// sleep length: rounded-up product, then divide by 1000 via reciprocal
		if (state_q == S_PREP) begin
			msr_q <= 32'(item_q.sleep_ms) * 32'(rate_q) + MS_ROUND;
		end
		if (state_q == S_SMUL) begin
			recip_q <= 64'(msr_q) * 64'(MS_RECIP);
		end
		if (state_q == S_SDIV) begin
			end_q <= tc_q + 32'(recip_q[63:MS_RECIP_SHIFT]);
		end
		if ((state_q == S_UDIV) && drsp.done) begin
			upt_q <= (rate_q == 16'd0) ? 32'd0 : drsp.quotient;
		end
		if ((state_q == S_CCHK) && hit) begin
			prod_q <= 40'(per_rd_q) * 40'(rate_q);
		end
		if ((state_q == S_RSCAN) && !valid_q[idx_q]) begin
			prod_q <= 40'(item_q.period_q8) * 40'(rate_q);
		end
		// result skeleton, fields filled per case
		res_q.tick_now <= tc_q;
		res_q.uptime_seconds <= upt_q;
		res_q.last <= 1'b0;
		case (state_q)
			S_WAKE: begin
				res_q.event_res <= EV_WOKEN;
				res_q.channel <= 3'd0;
				res_q.deadline <= 32'd0;
				res_q.already_due <= 1'b0;
				ret_q <= S_CRD;
			end
			S_CFIRE: begin
				res_q.event_res <= EV_FIRED;
				res_q.channel <= 3'(idx_q);
				res_q.deadline <= new_dl;
				res_q.already_due <= 1'b0;
				ret_q <= S_CNEXT;
			end
			S_RSCAN: begin
				res_q.event_res <= EV_FULL;
				res_q.channel <= 3'd0;
				res_q.deadline <= 32'd0;
				res_q.already_due <= 1'b0;
				ret_q <= S_FIN;
			end
			S_RWR: begin
				res_q.event_res <= EV_REGISTERED;
				res_q.channel <= 3'(idx_q);
				res_q.deadline <= new_dl;
				res_q.already_due <= 1'b0;
				ret_q <= S_FIN;
			end
			S_SLEEP: begin
				res_q.event_res <= EV_NONE;
				res_q.channel <= 3'd0;
				res_q.deadline <= end_q;
				res_q.already_due <= (tc_q >= end_q);
				ret_q <= S_FIN;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			tc_q <= 32'd0;
			earliest_q <= '1;
			valid_q <= '0;
			idx_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_data;
			end
			if (pop && (head.item.func == FUNC_TICK)) begin
				tc_q <= tc_q + 32'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_UDIV: idx_q <= '0;
				S_WAKE: begin
					if (tc_q >= earliest_q) begin
						earliest_q <= '1;
					end
				end
				S_CNEXT: begin
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_RSCAN: begin
					if (valid_q[idx_q] && (idx_q != LAST_IDX)) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_RWR: valid_q[idx_q] <= 1'b1;
				S_SLEEP: begin
					if (!(tc_q >= end_q) && (end_q < earliest_q)) begin
						earliest_q <= end_q;
					end
				end
				S_EMIT: begin
					if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/tick_timer_with_periodic_channels.sv */
// a register item walks the channels up to the first free one, a tick item walks every
// channel and emits one result per firing channel and one for a wake
// every result but the last waits in the back end for the next one
// throughput: one item at a time; the next item is taken only once the last result is loaded
// into the output register, and the serial uptime divider and the channel walk set the pace
// reset: arst_n clears tick count and channel valid bits, sets the wake deadline to all ones and rate to 100
module tick_timer_with_periodic_channels import tt_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [15:0] cfg_data
);

	queue_head_t head;
	logic pop;

	tt_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data (in_data),
		.head (head),
		.pop (pop)
	);

	tt_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_data (cfg_data),
		.head (head),
		.pop (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data (out_data)
	);

endmodule

/* bench/tick_timer_with_periodic_channels_tb.sv */
module tick_timer_with_periodic_channels_tb;
	import tt_pkg::*;

	localparam int NCHAN = 8;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [15:0] cfg_data;

	tick_timer_with_periodic_channels #(.CHANNELS(NCHAN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// timer state as the block should hold it
	logic [15:0] rate;
	logic [31:0] ticks;
	logic [31:0] wake_at;
	logic [31:0] chan_dl [NCHAN];
	logic [23:0] chan_per [NCHAN];
	logic chan_on [NCHAN];

	out_item_t pending_results[$];
	int mismatches;
	bit hold_long;
	int sent;

	typedef struct {
		logic [1:0] func;
		logic [23:0] period_q8;
		logic [15:0] sleep_ms;
		bit known;
		out_item_t want;
	} step_row_t;

	step_row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] period_span(logic [23:0] p);
		logic [39:0] prod;
		prod = 40'(p) * 40'(rate);
		return prod[39:8];
	endfunction

	function automatic out_item_t make_result(logic [2:0] ev, logic [2:0] ch,
			logic [31:0] dl, logic due);
		out_item_t r;
		r.event_res = ev;
		r.channel = ch;
		r.deadline = dl;
		r.already_due = due;
		r.tick_now = ticks;
		r.uptime_seconds = (rate == 16'd0) ? 32'd0 : ticks / 32'(rate);
		r.last = 1'b0;
		return r;
	endfunction

	// works out what one accepted item causes and moves the timer state on
	task automatic predict_timer(in_item_t it);
		out_item_t res[$];
		logic [47:0] prod;
		logic [31:0] fin;
		logic due;
		int slot;
		res = {};
		if (it.func == FUNC_TICK) begin
			ticks = ticks + 32'd1;
			if (ticks >= wake_at) begin
				wake_at = '1;
				res.push_back(make_result(EV_WOKEN, 3'd0, 32'd0, 1'b0));
			end
			for (int i = 0; i < NCHAN; i++) begin
				if (chan_on[i] && ticks >= chan_dl[i]) begin
					chan_dl[i] = ticks + period_span(chan_per[i]);
					res.push_back(make_result(EV_FIRED, 3'(i), chan_dl[i], 1'b0));
				end
			end
			if (res.size() == 0)
				res.push_back(make_result(EV_NONE, 3'd0, 32'd0, 1'b0));
		end else if (it.func == FUNC_REG) begin
			slot = -1;
			for (int i = NCHAN - 1; i >= 0; i--)
				if (!chan_on[i])
					slot = i;
			if (slot < 0) begin
				res.push_back(make_result(EV_FULL, 3'd0, 32'd0, 1'b0));
			end else begin
				chan_on[slot] = 1'b1;
				chan_per[slot] = it.period_q8;
				chan_dl[slot] = ticks + period_span(it.period_q8);
				res.push_back(make_result(EV_REGISTERED, 3'(slot), chan_dl[slot], 1'b0));
			end
		end else if (it.func == FUNC_SLEEP) begin
			prod = 48'(it.sleep_ms) * 48'(rate) + 48'(MS_ROUND);
			fin = ticks + 32'(prod / 48'(MS_PER_S));
			due = (ticks >= fin);
			if (!due && fin < wake_at)
				wake_at = fin;
			res.push_back(make_result(EV_NONE, 3'd0, fin, due));
		end else begin
			res.push_back(make_result(EV_NONE, 3'd0, 32'd0, 1'b0));
		end
		res[res.size() - 1].last = 1'b1;
		foreach (res[k])
			pending_results.push_back(res[k]);
	endtask

	// checking of the results
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				want = pending_results.pop_front();
				if (out_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, out_data);
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int mode;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (1500) @(posedge clk);
				hold_long = 1'b0;
			end
			mode = $urandom_range(0, 9);
			if (mode < 3)
				out_stall <= 1'b0;
			else if (mode < 8)
				out_stall <= ($urandom_range(0, 3) == 0);
			else
				out_stall <= 1'b1;
		end
	end

	task automatic send_item(in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_timer(it);
		sent++;
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	task automatic settle_and_set_rate(logic [15:0] r);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate = r;
	endtask

	function automatic in_item_t rand_item();
		in_item_t it;
		int k;
		k = $urandom_range(0, 99);
		it.func = (k < 60) ? FUNC_TICK : (k < 75) ? FUNC_REG : (k < 97) ? FUNC_SLEEP : 2'd3;
		// mostly short periods and sleeps so channels actually fire
		if ($urandom_range(0, 7) == 0)
			it.period_q8 = 24'($urandom);
		else
			it.period_q8 = 24'($urandom_range(0, 3000));
		if ($urandom_range(0, 7) == 0)
			it.sleep_ms = 16'($urandom);
		else
			it.sleep_ms = 16'($urandom_range(0, 200));
		return it;
	endfunction

	task automatic add_row(logic [1:0] f, logic [23:0] p, logic [15:0] ms, bit kn,
			out_item_t w);
		step_row_t r;
		r.func = f;
		r.period_q8 = p;
		r.sleep_ms = ms;
		r.known = kn;
		r.want = w;
		rows.push_back(r);
	endtask

	initial begin
		in_item_t it;
		out_item_t w;
		logic [15:0] rates [5];
		mismatches = 0;
		sent = 0;
		hold_long = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		rate = RATE_RESET;
		ticks = '0;
		wake_at = '1;
		for (int i = 0; i < NCHAN; i++) begin
			chan_on[i] = 1'b0;
			chan_dl[i] = '0;
			chan_per[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; a few expectations typed in straight from reset state
		w = '{event_res: EV_NONE, channel: 3'd0, deadline: 32'd0, already_due: 1'b0,
			tick_now: 32'd1, uptime_seconds: 32'd0, last: 1'b1};
		add_row(FUNC_TICK, 24'hFFFFFF, 16'hFFFF, 1'b1, w);
		w = '{event_res: EV_NONE, channel: 3'd0, deadline: 32'd1, already_due: 1'b1,
			tick_now: 32'd1, uptime_seconds: 32'd0, last: 1'b1};
		add_row(FUNC_SLEEP, 24'd0, 16'd0, 1'b1, w);
		w = '{event_res: EV_REGISTERED, channel: 3'd0, deadline: 32'd1, already_due: 1'b0,
			tick_now: 32'd1, uptime_seconds: 32'd0, last: 1'b1};
		add_row(FUNC_REG, 24'd0, 16'd0, 1'b1, w);
		w = '{event_res: EV_NONE, channel: 3'd0, deadline: 32'd0, already_due: 1'b0,
			tick_now: 32'd1, uptime_seconds: 32'd0, last: 1'b1};
		add_row(2'd3, 24'hFFFFFF, 16'hFFFF, 1'b1, w);
		add_row(FUNC_REG, 24'hFFFFFF, 16'd0, 1'b0, w);
		add_row(FUNC_REG, 24'd256, 16'd0, 1'b0, w);
		add_row(FUNC_REG, 24'd128, 16'd0, 1'b0, w);
		add_row(FUNC_SLEEP, 24'd0, 16'd10, 1'b0, w);
		add_row(FUNC_SLEEP, 24'd0, 16'hFFFF, 1'b0, w);
		for (int i = 0; i < 5; i++)
			add_row(FUNC_REG, 24'(i * 97), 16'd0, 1'b0, w);
		add_row(FUNC_REG, 24'd5, 16'd0, 1'b0, w);
		for (int i = 0; i < 6; i++)
			add_row(FUNC_TICK, 24'd0, 16'd0, 1'b0, w);
		foreach (rows[k]) begin
			it.func = rows[k].func;
			it.period_q8 = rows[k].period_q8;
			it.sleep_ms = rows[k].sleep_ms;
			if (rows[k].known) begin
				predict_timer(it);
				void'(pending_results.pop_back());
				pending_results.push_back(rows[k].want);
				in_valid <= 1'b1;
				in_data <= it;
				@(posedge clk);
				while (in_stall)
					@(posedge clk);
			end else begin
				send_item(it);
			end
		end

		// receiver goes quiet while items keep coming
		hold_long = 1'b1;
		for (int i = 0; i < 20; i++)
			send_item('{func: FUNC_TICK, period_q8: 24'd0, sleep_ms: 16'd0});

		// zero rate, both extremes, and a couple of ordinary settings
		rates = '{16'd0, 16'd65535, 16'd1, 16'd1000, RATE_RESET};
		foreach (rates[r]) begin
			settle_and_set_rate(rates[r]);
			for (int i = 0; i < 60; i++) begin
				it = rand_item();
				if (rates[r] == 16'd65535)
					it.period_q8 = 24'($urandom_range(0, 8));
				send_item(it);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
